// ===== hw/rtl/mldchk_pkg.sv =====
// Shared types, constants and decode functions for the MLD message checker.
`default_nettype none
package mldchk_pkg;

    localparam int MAX_MESSAGE_BYTES = 65535;
    localparam int OFF_W = 20;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] TYPE_QUERY = 8'd130;
    localparam logic [7:0] TYPE_REPORT_V1 = 8'd131;
    localparam logic [7:0] TYPE_DONE_V1 = 8'd132;
    localparam logic [7:0] TYPE_REPORT_V2 = 8'd143;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_V1 = 2'd1;
    localparam logic [1:0] VER_V2 = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_CUT_SHORT = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  type_value;
        logic [1:0]  version;
        logic [22:0] response_delay;
        logic [14:0] query_interval;
        logic        suppress;
        logic [2:0]  robustness;
        logic [15:0] item_count;
        logic [9:0]  aux_bytes;
        logic [63:0] group_high;
        logic [63:0] group_low;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic    rec_valid;
        result_t rec;
        logic    sum_valid;
        result_t sum;
    } push_t;

    // Maximum response code: exponent form when the top bit is set.
    function automatic logic [22:0] mrc_decode(input logic [15:0] c);
        logic [22:0] mant;
        logic [3:0]  sh;
        mant = {10'd0, 1'b1, c[11:0]};
        sh = {1'b0, c[14:12]} + 4'd3;
        if (!c[15]) begin
            return {7'd0, c};
        end
        return mant << sh;
    endfunction

    // Querier query interval code: exponent form when the top bit is set.
    function automatic logic [14:0] qqic_decode(input logic [7:0] c);
        logic [14:0] mant;
        logic [3:0]  sh;
        mant = {10'd0, 1'b1, c[3:0]};
        sh = {1'b0, c[6:4]} + 4'd3;
        if (!c[7]) begin
            return {7'd0, c};
        end
        return mant << sh;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mldchk_parser.sv =====
// Input register, message state and per-byte result generation.
`default_nettype none
module mldchk_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    input  wire logic                 room,
    output mldchk_pkg::push_t         push
);

    localparam logic [mldchk_pkg::OFF_W-1:0] MAXO =
        mldchk_pkg::OFF_W'(mldchk_pkg::MAX_MESSAGE_BYTES);

    logic                            in_valid_reg;
    logic [7:0]                      in_byte_reg;
    logic                            in_last_reg;
    logic                            consume;

    logic [mldchk_pkg::OFF_W-1:0] offset_reg, offset_next;
    logic [7:0]                   type_reg, type_next;
    logic [15:0]                  hw_reg [4];
    logic [15:0]                  hw_next [4];
    logic [63:0]                  g0_reg, g0_next, g1_reg, g1_next;
    logic [7:0]                   qf0_reg, qf0_next, qf1_reg, qf1_next;
    logic [mldchk_pkg::OFF_W-1:0] rstart_reg, rstart_next;
    logic [mldchk_pkg::OFF_W-1:0] rend_reg, rend_next;
    logic [31:0]                  rh_reg, rh_next;
    logic [15:0]                  seen_reg, seen_next;
    logic                         mal_reg, mal_next;
    logic                         stop_reg, stop_next;

    logic [mldchk_pkg::OFF_W-1:0] p;
    logic [mldchk_pkg::OFF_W-1:0] rel;
    logic [1:0]                   widx;
    logic [21:0]                  rec_end;
    logic [7:0]                   rtype;
    logic [20:0]                  expected;
    logic                         cut, mal;
    mldchk_pkg::result_t          rec, sum;
    logic                         rec_valid;

    assign consume = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    always_comb begin
        p = offset_reg;
        offset_next = offset_reg;
        type_next = type_reg;
        for (int i = 0; i < 4; i++) begin
            hw_next[i] = hw_reg[i];
        end
        g0_next = g0_reg;
        g1_next = g1_reg;
        qf0_next = qf0_reg;
        qf1_next = qf1_reg;
        rstart_next = rstart_reg;
        rend_next = rend_reg;
        rh_next = rh_reg;
        seen_next = seen_reg;
        mal_next = mal_reg;
        stop_next = stop_reg;
        rel = p - rstart_reg;
        widx = 2'(((p - mldchk_pkg::OFF_W'(2)) >> 1));
        rec_end = '0;
        rtype = '0;
        rec = '0;
        rec_valid = 1'b0;

        if (p >= MAXO) begin
            mal_next = 1'b1;
        end else begin
            if (p == '0) begin
                type_next = in_byte_reg;
            end else if (p == mldchk_pkg::OFF_W'(1)) begin
                if (in_byte_reg != 8'd0) begin
                    mal_next = 1'b1;
                end
            end else if (p < mldchk_pkg::OFF_W'(8)) begin
                hw_next[widx] = {hw_reg[widx][7:0], in_byte_reg};
            end else if (type_reg == mldchk_pkg::TYPE_REPORT_V2) begin
                if (!stop_reg) begin
                    if (seen_reg >= hw_reg[2]) begin
                        mal_next = 1'b1;
                    end else if (rel < mldchk_pkg::OFF_W'(4)) begin
                        rh_next = {rh_reg[23:0], in_byte_reg};
                        if (rel == mldchk_pkg::OFF_W'(3)) begin
                            rec_end = 22'(rstart_reg) + 22'd20 + {2'd0, rh_next[15:0], 4'd0}
                                      + {12'd0, rh_next[23:16], 2'd0};
                            if (rec_end > 22'(MAXO)) begin
                                stop_next = 1'b1;
                            end else begin
                                rend_next = rec_end[mldchk_pkg::OFF_W-1:0];
                            end
                        end
                    end else begin
                        if (rel < mldchk_pkg::OFF_W'(20)) begin
                            g0_next = {g0_reg[55:0], g1_reg[63:56]};
                            g1_next = {g1_reg[55:0], in_byte_reg};
                        end
                        if (rel >= mldchk_pkg::OFF_W'(19) &&
                            p + mldchk_pkg::OFF_W'(1) == rend_reg) begin
                            rtype = rh_reg[31:24];
                            rec_valid = 1'b1;
                            rec.kind = mldchk_pkg::KIND_RECORD;
                            rec.type_value = rtype;
                            rec.version = mldchk_pkg::VER_V2;
                            rec.item_count = rh_reg[15:0];
                            rec.aux_bytes = {rh_reg[23:16], 2'd0};
                            rec.group_high = g0_next;
                            rec.group_low = g1_next;
                            rec.status = (rtype < 8'd1 || rtype > 8'd6) ?
                                         mldchk_pkg::STATUS_MALFORMED :
                                         mldchk_pkg::STATUS_OK;
                            seen_next = seen_reg + 16'd1;
                            rstart_next = rend_reg;
                        end
                    end
                end
            end else if (p < mldchk_pkg::OFF_W'(24)) begin
                g0_next = {g0_reg[55:0], g1_reg[63:56]};
                g1_next = {g1_reg[55:0], in_byte_reg};
            end else if (p == mldchk_pkg::OFF_W'(24)) begin
                qf0_next = in_byte_reg;
            end else if (p == mldchk_pkg::OFF_W'(25)) begin
                qf1_next = in_byte_reg;
            end else if (p < mldchk_pkg::OFF_W'(28)) begin
                hw_next[3] = {hw_reg[3][7:0], in_byte_reg};
            end
            offset_next = p + mldchk_pkg::OFF_W'(1);
        end
    end

    // Summary, built from the state as it stands after the current byte.
    always_comb begin
        sum = '0;
        sum.kind = mldchk_pkg::KIND_SUMMARY;
        sum.type_value = type_next;
        cut = offset_next < mldchk_pkg::OFF_W'(2);
        mal = mal_next;
        expected = 21'd28 + {1'b0, hw_next[3], 4'd0};
        if (type_next == mldchk_pkg::TYPE_QUERY || type_next == mldchk_pkg::TYPE_REPORT_V1 ||
            type_next == mldchk_pkg::TYPE_DONE_V1) begin
            if (type_next != mldchk_pkg::TYPE_QUERY || offset_next == mldchk_pkg::OFF_W'(24)) begin
                sum.version = mldchk_pkg::VER_V1;
                if (offset_next < mldchk_pkg::OFF_W'(24)) begin
                    cut = 1'b1;
                end else begin
                    sum.response_delay = {7'd0, hw_next[1]};
                    sum.group_high = g0_next;
                    sum.group_low = g1_next;
                    if (hw_next[2] != 16'd0 ||
                        (type_next != mldchk_pkg::TYPE_QUERY && hw_next[1] != 16'd0)) begin
                        mal = 1'b1;
                    end
                    if (offset_next != mldchk_pkg::OFF_W'(24)) begin
                        mal = 1'b1;
                    end
                end
            end else begin
                sum.version = mldchk_pkg::VER_V2;
                if (offset_next < mldchk_pkg::OFF_W'(28)) begin
                    cut = 1'b1;
                end else begin
                    sum.response_delay = mldchk_pkg::mrc_decode(hw_next[1]);
                    sum.query_interval = mldchk_pkg::qqic_decode(qf1_next);
                    sum.suppress = qf0_next[3];
                    sum.robustness = qf0_next[2:0];
                    sum.item_count = hw_next[3];
                    sum.group_high = g0_next;
                    sum.group_low = g1_next;
                    if (hw_next[2] != 16'd0 || qf0_next[7:4] != 4'd0) begin
                        mal = 1'b1;
                    end
                    if (expected > 21'(offset_next)) begin
                        cut = 1'b1;
                    end else if (expected != 21'(offset_next)) begin
                        mal = 1'b1;
                    end
                end
            end
        end else if (type_next == mldchk_pkg::TYPE_REPORT_V2) begin
            sum.version = mldchk_pkg::VER_V2;
            if (offset_next < mldchk_pkg::OFF_W'(8)) begin
                cut = 1'b1;
            end else begin
                sum.item_count = hw_next[2];
                if (hw_next[1] != 16'd0) begin
                    mal = 1'b1;
                end
                if (stop_next || seen_next < hw_next[2]) begin
                    cut = 1'b1;
                end
            end
        end else begin
            mal = 1'b1;
        end
        sum.status = cut ? mldchk_pkg::STATUS_CUT_SHORT :
                     (mal ? mldchk_pkg::STATUS_MALFORMED : mldchk_pkg::STATUS_OK);
    end

    assign push.rec_valid = consume && rec_valid;
    assign push.rec = rec;
    assign push.sum_valid = consume && in_last_reg;
    assign push.sum = sum;

    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && in_last_reg)) begin
            offset_reg <= '0;
            type_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                hw_reg[i] <= '0;
            end
            g0_reg <= '0;
            g1_reg <= '0;
            qf0_reg <= '0;
            qf1_reg <= '0;
            rstart_reg <= mldchk_pkg::OFF_W'(8);
            rend_reg <= '0;
            rh_reg <= '0;
            seen_reg <= '0;
            mal_reg <= 1'b0;
            stop_reg <= 1'b0;
        end else if (consume) begin
            offset_reg <= offset_next;
            type_reg <= type_next;
            for (int i = 0; i < 4; i++) begin
                hw_reg[i] <= hw_next[i];
            end
            g0_reg <= g0_next;
            g1_reg <= g1_next;
            qf0_reg <= qf0_next;
            qf1_reg <= qf1_next;
            rstart_reg <= rstart_next;
            rend_reg <= rend_next;
            rh_reg <= rh_next;
            seen_reg <= seen_next;
            mal_reg <= mal_next;
            stop_reg <= stop_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mldchk_out_fifo.sv =====
// Result queue that takes up to two results per cycle and hands out one.
`default_nettype none
module mldchk_out_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mldchk_pkg::push_t    push,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output mldchk_pkg::result_t       out_data
);

    mldchk_pkg::result_t              mem_reg [mldchk_pkg::FIFO_DEPTH];
    logic [mldchk_pkg::PTR_W-1:0]     wr_reg, rd_reg;
    logic [mldchk_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [mldchk_pkg::PTR_W-1:0]     wr_next;
    logic [1:0]                       n_push;
    logic                             pop;

    assign n_push = {1'b0, push.rec_valid} + {1'b0, push.sum_valid};
    assign pop = out_valid && out_ready;
    assign room = count_reg <= mldchk_pkg::CNT_W'(mldchk_pkg::FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data = mem_reg[rd_reg];
    assign wr_next = wr_reg + mldchk_pkg::PTR_W'(n_push);
    assign count_next = count_reg + mldchk_pkg::CNT_W'(n_push)
                        - mldchk_pkg::CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.rec_valid) begin
            mem_reg[wr_reg] <= push.rec;
        end
        if (push.sum_valid) begin
            mem_reg[wr_reg + mldchk_pkg::PTR_W'(push.rec_valid)] <= push.sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            count_reg <= count_next;
            if (pop) begin
                rd_reg <= rd_reg + mldchk_pkg::PTR_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mldchk_pkg::CNT_W'(mldchk_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_push != 2'd0) |-> room)
        else $error("results pushed without two free slots");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && n_push == 2'd0) |=> count_reg == $past(count_reg) - mldchk_pkg::CNT_W'(1))
        else $error("result queue count did not drop after a pop");

endmodule
`default_nettype wire

// ===== hw/rtl/mld_message_checker_unit.sv =====
// Top level of the MLD message checker: stream ports, parser and result queue.
`default_nettype none
// The checker takes one ICMPv6 MLD message as a run of byte beats on the slave
// side, starting at the type byte, with s_tlast set on the final byte. It checks
// type, code, reserved fields, query flags and lengths, sorts the message into
// MLDv1 (type 130 of length 24, 131, 132) or MLDv2 (other 130 lengths, 143), and
// decodes the v2 exponent forms of the maximum response code and the QQIC. For a
// v2 report it emits one record beat (m_tuser high) as each record's last byte
// arrives, and for every message one summary beat (m_tuser low) on the last byte,
// whose status says well formed, malformed, or cut short; state then returns to
// its reset values for the next message. Source addresses and aux data contents
// are skipped. The block accepts one byte beat every cycle unless stalled: each
// accepted byte is held in an input register and processed from there into a
// four-entry result queue, whose head drives the master side. Since one byte
// can cause two results, the slave side stalls only while fewer than two queue
// slots are free, that is, when the master side has been stalled. Offsets count
// up to 65535 bytes; bytes beyond that are dropped and the message is marked
// malformed.
module mld_message_checker_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // last_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // type_value, version, response_delay, query_interval, suppress, robustness,
    // item_count, aux_bytes, group_high, group_low, status
    output logic [207:0]      m_tdata,
    output logic              m_tuser    // kind
);

    mldchk_pkg::push_t   push;
    mldchk_pkg::result_t head;
    logic                room;

    mldchk_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .room     (room),
        .push     (push)
    );

    mldchk_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Fields packed from the lowest bit up, type_value first.
    assign m_tdata = {head.status, head.group_low, head.group_high, head.aux_bytes,
                      head.item_count, head.robustness, head.suppress,
                      head.query_interval, head.response_delay, head.version,
                      head.type_value};
    assign m_tuser = head.kind;

endmodule
`default_nettype wire

// ===== tb/mld_result_checker.sv =====
// Result checker: predicts the MLD checker's result beats from its byte beats and compares them.
`timescale 1ns / 100ps
module mld_result_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // last_byte
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    // type_value, version, response_delay, query_interval, suppress, robustness,
    // item_count, aux_bytes, group_high, group_low, status
    input  wire logic [207:0] m_tdata,
    input  wire logic         m_tuser,   // kind
    output int                errors,
    output int                pending
);
    import mldchk_pkg::*;

    localparam logic [7:0] REC_TYPE_MIN = 8'd1;
    localparam logic [7:0] REC_TYPE_MAX = 8'd6;

    // Model of the parser state.
    logic [19:0] msg_offset;
    logic [7:0]  msg_type;
    logic [15:0] hdr_word [4];    // checksum, bytes 4-5, bytes 6-7, query source count
    logic [63:0] grp_addr [2];
    logic [7:0]  qry_flags [2];   // flags, QQIC
    int unsigned rec_start;
    int unsigned rec_end;
    logic [31:0] rec_hdr;         // record type, aux length, source count
    logic [15:0] recs_done;
    bit          bad_msg;
    bit          rec_stop;

    result_t     queued_verdicts [$];

    function automatic logic [22:0] response_value(input logic [15:0] code);
        int unsigned mant;
        mant = code[11:0] + 4096;
        if (!code[15]) begin
            return code;
        end
        return 23'(mant << (code[14:12] + 3));
    endfunction

    function automatic logic [14:0] interval_value(input logic [7:0] code);
        int unsigned mant;
        mant = code[3:0] + 16;
        if (!code[7]) begin
            return code;
        end
        return 15'(mant << (code[6:4] + 3));
    endfunction

    task automatic clear_parser();
        msg_offset = '0;
        msg_type = '0;
        for (int i = 0; i < 4; i++) begin
            hdr_word[i] = '0;
        end
        grp_addr[0] = '0;
        grp_addr[1] = '0;
        qry_flags[0] = '0;
        qry_flags[1] = '0;
        rec_start = 8;
        rec_end = 0;
        rec_hdr = '0;
        recs_done = '0;
        bad_msg = 1'b0;
        rec_stop = 1'b0;
    endtask

    task automatic shift_group(input logic [7:0] b);
        grp_addr[0] = {grp_addr[0][55:0], grp_addr[1][63:56]};
        grp_addr[1] = {grp_addr[1][55:0], b};
    endtask

    // One byte of a v2 report body; a record verdict is queued on its last byte.
    task automatic record_byte(input logic [7:0] b, input int unsigned p);
        int unsigned rel;
        int unsigned fin;
        result_t     r;
        if (!rec_stop) begin
            if (recs_done >= hdr_word[2]) begin
                bad_msg = 1'b1;
            end else begin
                rel = p - rec_start;
                if (rel < 4) begin
                    rec_hdr = {rec_hdr[23:0], b};
                    if (rel == 3) begin
                        fin = rec_start + 20 + (rec_hdr[15:0] << 4) + (rec_hdr[23:16] << 2);
                        if (fin > MAX_MESSAGE_BYTES) begin
                            rec_stop = 1'b1;
                        end else begin
                            rec_end = fin;
                        end
                    end
                end else begin
                    if (rel < 20) begin
                        shift_group(b);
                    end
                    if (rel >= 19 && p + 1 == rec_end) begin
                        r = '0;
                        r.kind = KIND_RECORD;
                        r.type_value = rec_hdr[31:24];
                        r.version = VER_V2;
                        r.item_count = rec_hdr[15:0];
                        r.aux_bytes = {rec_hdr[23:16], 2'b00};
                        r.group_high = grp_addr[0];
                        r.group_low = grp_addr[1];
                        r.status = (r.type_value < REC_TYPE_MIN || r.type_value > REC_TYPE_MAX)
                                   ? STATUS_MALFORMED : STATUS_OK;
                        queued_verdicts.push_back(r);
                        recs_done = recs_done + 1'b1;
                        rec_start = rec_end;
                    end
                end
            end
        end
    endtask

    // Summary verdict for the message that has just ended.
    task automatic close_message();
        int unsigned len;
        int unsigned need;
        bit          cut;
        bit          mal;
        result_t     r;
        len = msg_offset;
        cut = (len < 2);
        mal = bad_msg;
        r = '0;
        r.kind = KIND_SUMMARY;
        r.type_value = msg_type;
        if (msg_type == TYPE_QUERY || msg_type == TYPE_REPORT_V1 || msg_type == TYPE_DONE_V1) begin
            if (msg_type != TYPE_QUERY || len == 24) begin
                r.version = VER_V1;
                if (len < 24) begin
                    cut = 1'b1;
                end else begin
                    r.response_delay = hdr_word[1];
                    r.group_high = grp_addr[0];
                    r.group_low = grp_addr[1];
                    if (hdr_word[2] != 0 || (msg_type != TYPE_QUERY && hdr_word[1] != 0)) begin
                        mal = 1'b1;
                    end
                    if (len != 24) begin
                        mal = 1'b1;
                    end
                end
            end else begin
                r.version = VER_V2;
                if (len < 28) begin
                    cut = 1'b1;
                end else begin
                    need = hdr_word[3];
                    need = 28 + (need << 4);
                    r.response_delay = response_value(hdr_word[1]);
                    r.query_interval = interval_value(qry_flags[1]);
                    r.suppress = qry_flags[0][3];
                    r.robustness = qry_flags[0][2:0];
                    r.item_count = hdr_word[3];
                    r.group_high = grp_addr[0];
                    r.group_low = grp_addr[1];
                    if (hdr_word[2] != 0 || qry_flags[0][7:4] != 0) begin
                        mal = 1'b1;
                    end
                    if (need > len) begin
                        cut = 1'b1;
                    end else if (need != len) begin
                        mal = 1'b1;
                    end
                end
            end
        end else if (msg_type == TYPE_REPORT_V2) begin
            r.version = VER_V2;
            if (len < 8) begin
                cut = 1'b1;
            end else begin
                r.item_count = hdr_word[2];
                if (hdr_word[1] != 0) begin
                    mal = 1'b1;
                end
                if (rec_stop || recs_done < hdr_word[2]) begin
                    cut = 1'b1;
                end
            end
        end else begin
            mal = 1'b1;
        end
        r.status = cut ? STATUS_CUT_SHORT : (mal ? STATUS_MALFORMED : STATUS_OK);
        queued_verdicts.push_back(r);
    endtask

    task automatic track_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        int          w;
        p = msg_offset;
        if (p >= MAX_MESSAGE_BYTES) begin
            bad_msg = 1'b1;
        end else begin
            if (p == 0) begin
                msg_type = b;
            end else if (p == 1) begin
                if (b != 0) begin
                    bad_msg = 1'b1;
                end
            end else if (p < 8) begin
                w = (p - 2) >> 1;
                hdr_word[w] = {hdr_word[w][7:0], b};
            end else if (msg_type == TYPE_REPORT_V2) begin
                record_byte(b, p);
            end else if (p < 24) begin
                shift_group(b);
            end else if (p == 24) begin
                qry_flags[0] = b;
            end else if (p == 25) begin
                qry_flags[1] = b;
            end else if (p < 28) begin
                hdr_word[3] = {hdr_word[3][7:0], b};
            end
            msg_offset = p + 1;
        end
        if (last) begin
            close_message();
            clear_parser();
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_beat();
        result_t want;
        if (queued_verdicts.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual tuser %0b tdata %0h",
                     $time, m_tuser, m_tdata);
            errors++;
        end else begin
            want = queued_verdicts.pop_front();
            compare_field("kind", want.kind, m_tuser);
            compare_field("type_value", want.type_value, m_tdata[7:0]);
            compare_field("version", want.version, m_tdata[9:8]);
            compare_field("response_delay", want.response_delay, m_tdata[32:10]);
            compare_field("query_interval", want.query_interval, m_tdata[47:33]);
            compare_field("suppress", want.suppress, m_tdata[48]);
            compare_field("robustness", want.robustness, m_tdata[51:49]);
            compare_field("item_count", want.item_count, m_tdata[67:52]);
            compare_field("aux_bytes", want.aux_bytes, m_tdata[77:68]);
            compare_field("group_high", want.group_high, m_tdata[141:78]);
            compare_field("group_low", want.group_low, m_tdata[205:142]);
            compare_field("status", want.status, m_tdata[207:206]);
        end
    endtask

    // Prediction runs before comparison: a result never leaves in the cycle of its byte.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            queued_verdicts.delete();
            errors = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_beat();
            end
        end
        pending = queued_verdicts.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the MLD message checker testbench: clock, reset, byte stimulus, result sink, verdict.
`timescale 1ns / 100ps
module tb_top;
    import mldchk_pkg::*;

    // The run is a few dozen directed messages, then random messages for about
    // RANDOM_BYTES byte beats, then one report long enough to hit the offset
    // saturation.
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_BYTES = 1900;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT = 15;
    localparam int LONG_MESSAGE_BYTES = MAX_MESSAGE_BYTES + 10;
    localparam int DRAIN_CYCLES = 20;

    // Type bytes outside the MLD set.
    localparam logic [7:0] TYPE_UNUSED_LOW = 8'h00;
    localparam logic [7:0] TYPE_UNUSED_HIGH = 8'hff;

    // Multicast address record types; the last two lie outside the defined range.
    localparam logic [7:0] REC_MODE_IS_INCLUDE = 8'd1;
    localparam logic [7:0] REC_MODE_IS_EXCLUDE = 8'd2;
    localparam logic [7:0] REC_CHANGE_TO_INCLUDE = 8'd3;
    localparam logic [7:0] REC_CHANGE_TO_EXCLUDE = 8'd4;
    localparam logic [7:0] REC_ALLOW_NEW_SOURCES = 8'd5;
    localparam logic [7:0] REC_BLOCK_OLD_SOURCES = 8'd6;
    localparam logic [7:0] REC_TYPE_ZERO = 8'd0;
    localparam logic [7:0] REC_TYPE_SEVEN = 8'd7;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [207:0] m_tdata;
    logic         m_tuser;

    int           errors;
    int           pending;
    int           cycle_count = 0;
    int           bytes_sent = 0;

    // Idle control. The steady flags switch idling off on one side; the hold
    // request asks the receiver for one long stall, which it counts itself.
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    bit           hold_req = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_count = 0;

    // Bytes of the message being built, type byte first.
    logic [7:0]   msg [$];

    mld_message_checker_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mld_result_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // A hung block or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mld_message_checker_unit test failed");
            $finish;
        end
    end

    // Result sink. Exactly one assignment to m_tready per rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Random value that is zero most of the time, for fields that should be zero.
    function automatic logic [15:0] seldom(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            return $urandom_range(1, 16'hffff);
        end
        return 16'd0;
    endfunction

    task automatic push16(input logic [15:0] v);
        msg.push_back(v[15:8]);
        msg.push_back(v[7:0]);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) begin
            msg.push_back($urandom_range(0, 255));
        end
    endtask

    task automatic cut_to(input int n);
        while (msg.size() > n) begin
            msg.pop_back();
        end
    endtask

    // MLDv1 layout: type, code, checksum, maximum response delay, reserved, group.
    task automatic make_v1(input logic [7:0] t, input logic [7:0] code,
                           input logic [15:0] delay, input logic [15:0] rsv);
        msg.delete();
        msg.push_back(t);
        msg.push_back(code);
        push_random(2);
        push16(delay);
        push16(rsv);
        push_random(16);
    endtask

    // MLDv2 query: the v1 layout, then flags, QQIC, source count and sources.
    task automatic make_query_v2(input logic [7:0] code, input logic [15:0] mrc,
                                 input logic [15:0] rsv, input logic [7:0] flags,
                                 input logic [7:0] qqic, input logic [15:0] nsrc);
        msg.delete();
        msg.push_back(TYPE_QUERY);
        msg.push_back(code);
        push_random(2);
        push16(mrc);
        push16(rsv);
        push_random(16);
        msg.push_back(flags);
        msg.push_back(qqic);
        push16(nsrc);
        push_random(nsrc * 16);
    endtask

    // MLDv2 report header: type, code, checksum, reserved, record count.
    task automatic start_report(input logic [7:0] code, input logic [15:0] rsv,
                                input logic [15:0] nrec);
        msg.delete();
        msg.push_back(TYPE_REPORT_V2);
        msg.push_back(code);
        push_random(2);
        push16(rsv);
        push16(nrec);
    endtask

    task automatic add_record(input logic [7:0] rtype, input logic [7:0] aux,
                              input logic [15:0] nsrc);
        msg.push_back(rtype);
        msg.push_back(aux);
        push16(nsrc);
        push_random(16 + nsrc * 16 + aux * 4);
    endtask

    function automatic logic [7:0] pick_record_type();
        if ($urandom_range(0, 99) < 10) begin
            return $urandom_range(0, 255);
        end
        return $urandom_range(REC_MODE_IS_INCLUDE, REC_BLOCK_OLD_SOURCES);
    endfunction

    // Drives the message one byte beat at a time. The ready level is taken at
    // the falling edge, so the beat is known to move at the next rising edge.
    // Each beat leaves s_tvalid high; the caller lowers it when a pause follows.
    task automatic send_msg();
        logic ok;
        for (int i = 0; i < msg.size(); i++) begin
            if (!tx_steady) begin
                while ($urandom_range(0, 99) < IDLE_PCT) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata <= msg[i];
            s_tlast <= (i == msg.size() - 1);
            do begin
                @(negedge aclk);
                ok = s_tready;
                @(posedge aclk);
            end while (!ok);
            bytes_sent++;
        end
    endtask

    // Stops sending and waits until every predicted result has been seen.
    // The checker updates its count at the rising edge, so it is read at the
    // falling edge.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) begin
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    // Builds a random message: mostly well formed with random content, with
    // occasional bad fields, truncations, extra bytes and plain noise.
    task automatic make_random_msg();
        int sel;
        int nrec;
        int nput;
        logic [7:0] t;
        logic [7:0] flags;
        logic [7:0] aux;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            case ($urandom_range(0, 2))
                0: t = TYPE_QUERY;
                1: t = TYPE_REPORT_V1;
                default: t = TYPE_DONE_V1;
            endcase
            make_v1(t, seldom(8), (t == TYPE_QUERY) ? 16'($urandom_range(0, 16'hffff))
                                                    : seldom(10), seldom(8));
        end else if (sel < 45) begin
            flags = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 8) begin
                flags[7:4] = $urandom_range(1, 15);
            end
            make_query_v2(seldom(8), $urandom_range(0, 16'hffff), seldom(8), flags,
                          $urandom_range(0, 255),
                          ($urandom_range(0, 19) == 0) ? $urandom_range(4, 20)
                                                       : $urandom_range(0, 3));
        end else if (sel < 85) begin
            nrec = $urandom_range(0, 4);
            start_report(seldom(8), seldom(8), nrec);
            nput = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 5) : nrec;
            for (int i = 0; i < nput; i++) begin
                aux = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3);
                add_record(pick_record_type(), aux, $urandom_range(0, 2));
            end
        end else begin
            msg.delete();
            push_random($urandom_range(1, 40));
        end
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            cut_to($urandom_range(1, msg.size()));
        end else if (sel < 18) begin
            push_random($urandom_range(1, 4));
        end else if (sel < 23) begin
            msg[$urandom_range(0, msg.size() - 1)] = $urandom_range(0, 255);
        end
    endtask

    initial begin
        int random_start;
        int k;

        // Reset is held once, at the start, and never again.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed messages.
        // A lone type byte is cut short.
        msg.delete();
        msg.push_back(TYPE_QUERY);
        send_msg();
        // A v1 report that stops after its code byte.
        make_v1(TYPE_REPORT_V1, 8'h00, 16'h0000, 16'h0000);
        cut_to(2);
        send_msg();
        // Well-formed v1 query with the largest delay, v1 report and done.
        make_v1(TYPE_QUERY, 8'h00, 16'hffff, 16'h0000);
        send_msg();
        make_v1(TYPE_REPORT_V1, 8'h00, 16'h0000, 16'h0000);
        send_msg();
        make_v1(TYPE_DONE_V1, 8'h00, 16'h0000, 16'h0000);
        send_msg();
        // Nonzero delay in a done, nonzero code, nonzero reserved field.
        make_v1(TYPE_DONE_V1, 8'h00, 16'h0001, 16'h0000);
        send_msg();
        make_v1(TYPE_QUERY, 8'h80, 16'h1234, 16'h0000);
        send_msg();
        make_v1(TYPE_REPORT_V1, 8'h00, 16'h0000, 16'h8000);
        send_msg();
        // A v1 report with a byte too many.
        make_v1(TYPE_REPORT_V1, 8'h00, 16'h0000, 16'h0000);
        push_random(1);
        send_msg();
        // v2 queries: largest linear codes, then the exponent forms at their top.
        make_query_v2(8'h00, 16'h7fff, 16'h0000, 8'h0f, 8'h7f, 16'd0);
        send_msg();
        make_query_v2(8'h00, 16'hffff, 16'h0000, 8'h0a, 8'hff, 16'd2);
        send_msg();
        // High flag nibble set, with the smallest exponent codes.
        make_query_v2(8'h00, 16'h8000, 16'h0000, 8'hf0, 8'h80, 16'd1);
        send_msg();
        // Ends inside its sources, then inside its fixed header.
        make_query_v2(8'h00, 16'h0010, 16'h0000, 8'h02, 8'h7d, 16'd3);
        cut_to(40);
        send_msg();
        make_query_v2(8'h00, 16'h0010, 16'h0000, 8'h02, 8'h7d, 16'd0);
        cut_to(26);
        send_msg();
        // Bytes beyond the declared sources, and a nonzero reserved field.
        make_query_v2(8'h00, 16'h0400, 16'h0000, 8'h07, 8'h10, 16'd1);
        push_random(3);
        send_msg();
        make_query_v2(8'h00, 16'h0000, 16'h0100, 8'h00, 8'h00, 16'd0);
        send_msg();
        // v2 report with no records.
        start_report(8'h00, 16'h0000, 16'd0);
        send_msg();
        // Records of both out-of-range types among a valid one.
        start_report(8'h00, 16'h0000, 16'd3);
        add_record(REC_MODE_IS_INCLUDE, 8'd1, 16'd2);
        add_record(REC_TYPE_SEVEN, 8'd0, 16'd0);
        add_record(REC_TYPE_ZERO, 8'd0, 16'd1);
        send_msg();
        // One record more than declared, then one fewer.
        start_report(8'h00, 16'h0000, 16'd1);
        add_record(REC_BLOCK_OLD_SOURCES, 8'd0, 16'd0);
        add_record(REC_ALLOW_NEW_SOURCES, 8'd0, 16'd0);
        send_msg();
        start_report(8'h00, 16'h0000, 16'd2);
        add_record(REC_MODE_IS_EXCLUDE, 8'd2, 16'd1);
        send_msg();
        // Report that ends inside its header.
        start_report(8'h00, 16'h0000, 16'd1);
        cut_to(5);
        send_msg();
        // Nonzero code and reserved field, record with the largest aux length.
        start_report(8'h01, 16'h0001, 16'd2);
        add_record(REC_CHANGE_TO_EXCLUDE, 8'hff, 16'd0);
        add_record(REC_CHANGE_TO_INCLUDE, 8'd0, 16'd0);
        send_msg();
        // A record whose declared end lies past the offset limit stops parsing.
        start_report(8'h00, 16'h0000, 16'd1);
        msg.push_back(REC_MODE_IS_INCLUDE);
        msg.push_back(8'd0);
        push16(16'hffff);
        push_random(10);
        send_msg();
        // Unknown types, a full-length one and a lone byte.
        msg.delete();
        msg.push_back(TYPE_UNUSED_LOW);
        push_random(11);
        send_msg();
        msg.delete();
        msg.push_back(TYPE_UNUSED_HIGH);
        send_msg();

        // The sender pauses until every result so far has come out.
        drain();

        // Random messages. The receiver stalls for a long stretch at the start
        // while the sender keeps offering, so the result queue fills and the
        // byte side backs up. A later run of messages goes without idling.
        random_start = bytes_sent;
        hold_req = 1'b1;
        k = 0;
        while (bytes_sent < random_start + RANDOM_BYTES) begin
            tx_steady = (k >= 20 && k < 32);
            rx_steady = tx_steady;
            make_random_msg();
            send_msg();
            k++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();

        // One report with records packed up to and past the offset limit: the
        // record that crosses it stops parsing, and the bytes past the limit
        // are dropped.
        start_report(8'h00, 16'h0000, 16'hffff);
        while (msg.size() < LONG_MESSAGE_BYTES) begin
            add_record($urandom_range(REC_MODE_IS_INCLUDE, REC_BLOCK_OLD_SOURCES),
                       $urandom_range(0, 3), $urandom_range(0, 3));
        end
        cut_to(LONG_MESSAGE_BYTES);
        send_msg();

        // Let the last results out, then keep watching for stray beats.
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (errors == 0) begin
            $display("mld_message_checker_unit test passed");
        end else begin
            $display("mld_message_checker_unit test failed");
        end
        $finish;
    end

endmodule
